// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file fps_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion, off while reset is held
`define FPS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fps assertion failed");

// concurrent assertion, also checked through reset
`define FPS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("fps assertion failed during reset");

`endif

// ----- src/fps_pkg.sv -----
// ----------------------------------------------------------------------------
// fps_pkg
// widths, register indexes, limits, the match config and the case fold used by the search
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int PAT_LIMIT  = 32;
    localparam int PAT_IDX_W  = 5;
    localparam int LEN_W      = 6;
    localparam int LINE_W     = 24;
    localparam int COL_W      = 16;
    localparam int CNT_W      = 32;
    localparam int TAG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PAT0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAT2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAT3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CASE = 3'd5;

    localparam logic [7:0]        NEWLINE    = 8'h0A;
    localparam logic [7:0]        UPPER_A    = 8'h41;
    localparam logic [7:0]        UPPER_Z    = 8'h5A;
    localparam logic [7:0]        CASE_DELTA = 8'h20;
    localparam logic [LINE_W-1:0] LINE_MAX   = {LINE_W{1'b1}};
    localparam logic [COL_W-1:0]  COL_MAX    = {COL_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

    typedef struct packed {
        logic [PAT_LIMIT-1:0][7:0] apat;      // pattern byte expected at window lane
        logic [PAT_LIMIT-1:0]      lane_en;
        logic                      fold_en;
        logic [PAT_IDX_W-1:0]      start_sel; // window lane of the match start
        logic [LEN_W-1:0]          len_m1;
        logic                      len_zero;
    } t_match_cfg;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
        if (en && b >= UPPER_A && b <= UPPER_Z) begin
            return b + CASE_DELTA;
        end
        return b;
    endfunction

endpackage

// ----- src/fps_if.sv -----
// ----------------------------------------------------------------------------
// fps_in_if / fps_out_if
// valid/ready channels for text bytes and match results
// ----------------------------------------------------------------------------
interface fps_in_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                data_byte;
    logic [fps_pkg::TAG_W-1:0] file_tag;
    logic                      last_byte;

    modport source (output valid, output data_byte, output file_tag, output last_byte,
                    input ready);
    modport sink   (input valid, input data_byte, input file_tag, input last_byte,
                    output ready);
endinterface

interface fps_out_if;
    logic                       valid;
    logic                       ready;
    logic [fps_pkg::TAG_W-1:0]  match_file_tag;
    logic [fps_pkg::LINE_W-1:0] match_line;
    logic [fps_pkg::COL_W-1:0]  match_column;
    logic [fps_pkg::CNT_W-1:0]  match_offset;

    modport source (output valid, output match_file_tag, output match_line,
                    output match_column, output match_offset, input ready);
    modport sink   (input valid, input match_file_tag, input match_line,
                    input match_column, input match_offset, output ready);
endinterface

// ----- src/fps_cfg.sv -----
// ----------------------------------------------------------------------------
// fps_cfg
// configuration registers and the pattern aligned to the window lanes
// ----------------------------------------------------------------------------
module fps_cfg #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output fps_pkg::t_match_cfg              o_match_cfg
);
    import fps_pkg::*;

    logic [CFG_DATA_W-1:0]               r_pat [4];
    logic [LEN_W-1:0]                    r_len;
    logic                                r_ci;
    t_match_cfg                          r_mcfg;
    t_match_cfg                          n_mcfg;
    logic [LEN_W-1:0]                    len_c;
    logic [4*CFG_DATA_W-1:0]             pat_flat;
    logic [PAT_LIMIT-1:0][LEN_W-1:0]     src_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat[0] <= '0;
            r_pat[1] <= '0;
            r_pat[2] <= '0;
            r_pat[3] <= '0;
            r_len    <= LEN_W'(1);
            r_ci     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PAT0: r_pat[0] <= i_cfg_data;
                REG_PAT1: r_pat[1] <= i_cfg_data;
                REG_PAT2: r_pat[2] <= i_cfg_data;
                REG_PAT3: r_pat[3] <= i_cfg_data;
                REG_LEN:  r_len    <= i_cfg_data[LEN_W-1:0];
                REG_CASE: r_ci     <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    // pattern byte k lands on lane len-1-k, so lane 0 holds the last byte
    always_comb begin
        len_c    = (r_len > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : r_len;
        pat_flat = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};
        for (int j = 0; j < PAT_LIMIT; j++) begin
            src_idx[j]        = len_c - LEN_W'(1) - LEN_W'(j);
            n_mcfg.lane_en[j] = (LEN_W'(j) < len_c);
            n_mcfg.apat[j]    = fold_byte(pat_flat[8*src_idx[j][PAT_IDX_W-1:0] +: 8], r_ci);
        end
        n_mcfg.fold_en   = r_ci;
        n_mcfg.len_m1    = len_c - LEN_W'(1);
        n_mcfg.start_sel = n_mcfg.len_m1[PAT_IDX_W-1:0];
        n_mcfg.len_zero  = (len_c == '0);
    end

    always_ff @(posedge i_clk) begin
        r_mcfg <= n_mcfg;
    end

    assign o_match_cfg = r_mcfg;

endmodule

// ----- src/fixed_pattern_stream_search.sv -----
// ----------------------------------------------------------------------------
// fixed_pattern_stream_search
// streaming fixed pattern search with line, column and offset of each match
// ----------------------------------------------------------------------------
// usage:
//   i_in carries one text byte per item with its file tag and a last-byte flag;
//   o_out carries one item per match: file tag, 1-based line and column and
//   byte offset of the match start. matches may overlap. the pattern (1 to 32
//   bytes), length and case fold mode go in through i_cfg_*; the user must
//   write them only while no item is in flight, unchecked by the block.
// timing:
//   one item per cycle unless a match waits behind a held o_out. an accepted
//   byte shifts into the window; the 32-lane compare runs in the following
//   cycle and a match is registered onto o_out once it is free. the window
//   compare is the one stage. an item with no match leaves without a result.
// reset and stalls:
//   synchronous reset clears the window, line, column and byte count and
//   restores the registers to their defaults; i_in.ready is low under reset.
//   while o_out is held by the receiver, bytes keep flowing until a second
//   match waits behind it, then i_in.ready drops.
//   after a last byte the per-file state returns to its reset values.
// ----------------------------------------------------------------------------
module fixed_pattern_stream_search #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    fps_in_if.sink                           i_in,
    fps_out_if.source                        o_out
);
    import fps_pkg::*;

    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    t_match_cfg          mcfg;

    logic [7:0]          r_win_byte [PATTERN_MAX];
    logic [LINE_W-1:0]   r_win_line [PATTERN_MAX];
    logic [COL_W-1:0]    r_win_col  [PATTERN_MAX];
    logic [7:0]          n_win_byte [PATTERN_MAX];
    logic [LINE_W-1:0]   n_win_line [PATTERN_MAX];
    logic [COL_W-1:0]    n_win_col  [PATTERN_MAX];
    logic [LINE_W-1:0]   r_line, n_line, base_line;
    logic [COL_W-1:0]    r_col, n_col, base_col;
    logic [CNT_W-1:0]    r_cnt, n_cnt, base_cnt;

    logic                r_s1_valid;
    logic                r_s1_last;
    logic [TAG_W-1:0]    r_s1_tag;
    logic [CNT_W-1:0]    r_s1_idx;

    logic                r_out_valid;
    logic [TAG_W-1:0]    r_out_tag;
    logic [LINE_W-1:0]   r_out_line;
    logic [COL_W-1:0]    r_out_col;
    logic [CNT_W-1:0]    r_out_off;

    logic [PATTERN_MAX-1:0] lane_ok;
    logic                idx_ok;
    logic                hit;
    logic                out_free;
    logic                s1_adv;
    logic                in_ready;
    logic                accept;
    logic                file_clear;
    logic [CNT_W-1:0]    match_off;

    fps_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_match_cfg (mcfg)
    );

    // compare stage
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            lane_ok[j] = !mcfg.lane_en[j] ||
                         (fold_byte(r_win_byte[j], mcfg.fold_en) == mcfg.apat[j]);
        end
        idx_ok    = (r_s1_idx >= {{(CNT_W-LEN_W){1'b0}}, mcfg.len_m1});
        hit       = r_s1_valid && !mcfg.len_zero && idx_ok && (&lane_ok);
        match_off = (r_s1_idx == CNT_MAX) ? CNT_MAX
                                          : r_s1_idx - {{(CNT_W-LEN_W){1'b0}}, mcfg.len_m1};
    end

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_adv     = r_s1_valid && (!hit || out_free);
    assign in_ready   = i_rst_n && (!r_s1_valid || s1_adv);
    assign accept     = i_in.valid && in_ready;
    assign file_clear = s1_adv && r_s1_last;

    // window shift and position tracking
    always_comb begin
        base_line = file_clear ? LINE_W'(1) : r_line;
        base_col  = file_clear ? COL_W'(1)  : r_col;
        base_cnt  = file_clear ? '0         : r_cnt;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            n_win_byte[j] = file_clear ? 8'h00      : r_win_byte[j];
            n_win_line[j] = file_clear ? LINE_W'(1) : r_win_line[j];
            n_win_col[j]  = file_clear ? COL_W'(1)  : r_win_col[j];
        end
        n_line = base_line;
        n_col  = base_col;
        n_cnt  = base_cnt;
        if (accept) begin
            for (int j = PATTERN_MAX - 1; j > 0; j--) begin
                n_win_byte[j] = n_win_byte[j-1];
                n_win_line[j] = n_win_line[j-1];
                n_win_col[j]  = n_win_col[j-1];
            end
            n_win_byte[0] = i_in.data_byte;
            n_win_line[0] = base_line;
            n_win_col[0]  = base_col;
            if (i_in.data_byte == NEWLINE) begin
                n_line = (base_line == LINE_MAX) ? base_line : base_line + LINE_W'(1);
                n_col  = COL_W'(1);
            end else begin
                n_col  = (base_col == COL_MAX) ? base_col : base_col + COL_W'(1);
            end
            n_cnt = (base_cnt == CNT_MAX) ? base_cnt : base_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win_byte[j] <= 8'h00;
                r_win_line[j] <= LINE_W'(1);
                r_win_col[j]  <= COL_W'(1);
            end
            r_line      <= LINE_W'(1);
            r_col       <= COL_W'(1);
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            for (int j = 0; j < PATTERN_MAX; j++) begin
                r_win_byte[j] <= n_win_byte[j];
                r_win_line[j] <= n_win_line[j];
                r_win_col[j]  <= n_win_col[j];
            end
            r_line <= n_line;
            r_col  <= n_col;
            r_cnt  <= n_cnt;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_last <= i_in.last_byte;
            r_s1_tag  <= i_in.file_tag;
            r_s1_idx  <= base_cnt;
        end
        if (out_free && hit) begin
            r_out_tag  <= r_s1_tag;
            r_out_line <= r_win_line[mcfg.start_sel[IW-1:0]];
            r_out_col  <= r_win_col[mcfg.start_sel[IW-1:0]];
            r_out_off  <= match_off;
        end
    end

    assign i_in.ready           = in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.match_file_tag = r_out_tag;
    assign o_out.match_line     = r_out_line;
    assign o_out.match_column   = r_out_col;
    assign o_out.match_offset   = r_out_off;

endmodule

// ----- src/fps_checker.sv -----
// ----------------------------------------------------------------------------
// fps_checker
// port level checks of the search block, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fps_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [fps_pkg::TAG_W-1:0]   i_out_tag,
    input logic [fps_pkg::LINE_W-1:0]  i_out_line,
    input logic [fps_pkg::COL_W-1:0]   i_out_col,
    input logic [fps_pkg::CNT_W-1:0]   i_out_off
);

    // held result keeps its payload
    `FPS_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_tag) && $stable(i_out_line) && $stable(i_out_col) && $stable(i_out_off))

    // no result and no intake while reset is held
    `FPS_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_out_valid)
    `FPS_ASSERT_ALWAYS(a_rst_no_in, i_clk, !i_rst_n |-> !i_in_ready)

    // a fresh result follows an earlier accepted item
    `FPS_ASSERT(a_out_cause, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))

    // positions are 1-based
    `FPS_ASSERT(a_pos_nonzero, i_clk, i_rst_n, i_out_valid |-> i_out_line != '0 && i_out_col != '0)

endmodule

bind fixed_pattern_stream_search fps_checker u_fps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_tag   (o_out.match_file_tag),
    .i_out_line  (o_out.match_line),
    .i_out_col   (o_out.match_column),
    .i_out_off   (o_out.match_offset)
);
